// ----- src/lrufr_pkg.sv -----
package lrufr_pkg;

	// Field widths fixed by the stream formats
	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 16;

	// Command codes; the fourth code is unused and changes nothing
	typedef enum logic [1:0] {
		CMD_VICTIM = 2'd0,
		CMD_PIN    = 2'd1,
		CMD_UNPIN  = 2'd2
	} cmd_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
	} dp_ctrl_t;

endpackage

// ----- src/lrufr_ctrl.sv -----
module lrufr_ctrl
	import lrufr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output dp_ctrl_t dp_ctrl
);

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	// Result register can take a new result when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	// State register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_ctrl.update) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		dp_ctrl.capture = 1'b0;
		dp_ctrl.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dp_ctrl.capture = 1'b1;
					state_d         = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					dp_ctrl.update = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ----- src/lrufr_dp.sv -----
module lrufr_dp
	import lrufr_pkg::*;
#(
	parameter int FRAMES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_ctrl_t           dp_ctrl,
	input  logic [1:0]         in_cmd,
	input  logic [FRAME_W-1:0] in_frame,
	output logic               res_found,
	output logic [FRAME_W-1:0] res_frame,
	output logic [COUNT_W-1:0] res_count
);

	localparam int IDX_W = $clog2(FRAMES);
	localparam int CNT_W = $clog2(FRAMES + 1);

	// Recency list: entry 0 is the least recent, entry count-1 the most recent
	logic [FRAME_W-1:0] list_q [FRAMES];
	logic [CNT_W-1:0]   count_q;

	// Captured command
	logic [1:0]         cmd_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic               in_range_s1;
	logic [FRAMES-1:0]  match_s1;

	// Result register
	logic               found_q;
	logic [FRAME_W-1:0] vframe_q;

	logic [FRAMES-1:0]  match;
	logic               present;
	logic [IDX_W-1:0]   pos;
	logic               shift_all;
	logic               shift_part;
	logic               write_en;
	logic [CNT_W-1:0]   wpos;
	logic [CNT_W-1:0]   count_d;
	logic               found_d;
	logic [FRAME_W-1:0] vframe_d;

	// Per-cell compare against the incoming frame, live entries only
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (list_q[i] == in_frame);
		end
	end

	// Capture stage
	always_ff @(posedge clk) begin
		if (dp_ctrl.capture) begin
			cmd_s1      <= in_cmd;
			frame_s1    <= in_frame;
			in_range_s1 <= (int'(in_frame) < FRAMES);
			match_s1    <= match;
		end
	end

	// Encode the one-hot hit position
	always_comb begin
		present = |match_s1;
		pos     = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (match_s1[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	// Update decisions
	always_comb begin
		shift_all  = 1'b0;
		shift_part = 1'b0;
		write_en   = 1'b0;
		wpos       = count_q;
		count_d    = count_q;
		found_d    = 1'b0;
		vframe_d   = '0;
		case (cmd_s1)
			CMD_VICTIM: begin
				if (count_q != '0) begin
					shift_all = 1'b1;
					found_d   = 1'b1;
					vframe_d  = list_q[0];
					count_d   = count_q - 1'b1;
				end
			end
			CMD_PIN: begin
				if (in_range_s1 && present) begin
					shift_part = 1'b1;
					count_d    = count_q - 1'b1;
				end
			end
			CMD_UNPIN: begin
				if (in_range_s1) begin
					if (present) begin
						// close the gap, then put the frame on top
						shift_part = 1'b1;
						write_en   = 1'b1;
						wpos       = count_q - 1'b1;
					end else if (count_q < CNT_W'(FRAMES)) begin
						write_en = 1'b1;
						wpos     = count_q;
						count_d  = count_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// List cells: write at the top or take the neighbor above
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (dp_ctrl.update) begin
				if (write_en && wpos == CNT_W'(g)) begin
					list_q[g] <= frame_s1;
				end else if (shift_all || (shift_part && IDX_W'(g) >= pos)) begin
					if (g < FRAMES - 1) begin
						list_q[g] <= list_q[(g + 1) % FRAMES];
					end
				end
			end
		end
	end

	// Tracked count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_ctrl.update) begin
			count_q <= count_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (dp_ctrl.update) begin
			found_q  <= found_d;
			vframe_q <= vframe_d;
		end
	end

	assign res_found = found_q;
	assign res_frame = vframe_q;

	// Count as reported; the list never holds more than one entry per frame id
	if (CNT_W >= COUNT_W) begin : g_cnt_trunc
		assign res_count = count_q[COUNT_W-1:0];
	end else begin : g_cnt_ext
		assign res_count = {{(COUNT_W - CNT_W){1'b0}}, count_q};
	end

endmodule

// ----- src/lru_frame_replacer_top.sv -----
// LRU replacement list over buffer frames.
//
// Input stream (s_*): one transaction per command, tdata = {frame_num, cmd}.
//   cmd 0 takes the least recently unpinned frame as victim, cmd 1 pins
//   (drops) a frame, cmd 2 unpins a frame (makes it most recent).
// Output stream (m_*): exactly one transaction per command, carrying
//   victim_found, victim_frame and the tracked-frame count after the command.
//
// Timing: a command is captured in ST_IDLE and applied in ST_UPDATE once the
// result register is free, so the block takes no new command until the last
// one is applied; the result is valid on m_tvalid the cycle after the update.
// The list is a row of FRAMES registers with a compare per entry; the hit is
// registered at accept and the shift of the row happens in the update cycle.
// A result register sits on the output: the next command is accepted while a
// result waits. If the receiver stalls with a result still held, the next
// command waits in its update cycle and s_tready stays low until then.
//
// Reset clears the tracked count and the handshake state; the list is empty.
module lru_frame_replacer_top
	import lrufr_pkg::*;
#(
	parameter int FRAMES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // cmd[1:0], frame_num[7:2]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // victim_found[0], victim_frame[6:1],
	                                         // evictable_count[13:7], zero[15:14]
);

	dp_ctrl_t           dp_ctrl;
	logic               res_found;
	logic [FRAME_W-1:0] res_frame;
	logic [COUNT_W-1:0] res_count;

	// Controller
	lrufr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_ctrl  (dp_ctrl)
	);

	// List datapath
	lrufr_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_ctrl   (dp_ctrl),
		.in_cmd    (s_tdata[1:0]),
		.in_frame  (s_tdata[7:2]),
		.res_found (res_found),
		.res_frame (res_frame),
		.res_count (res_count)
	);

	// Output packing
	assign m_tdata = {2'b00, res_count, res_frame, res_found};

`ifndef NO_ASSERTIONS
	// No transaction is accepted in the cycle after one is accepted
	a_one_per_two: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted in back-to-back cycles");

	// Count never exceeds the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[13:7]) <= FRAMES)
		else $error("tracked count beyond list depth");

	// No victim reported means frame field is zero
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == '0)
		else $error("victim frame set without victim found");

	// A result appears only after a command was taken
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a command in update");
`endif

endmodule
